// ----- hdl/ctt_pkg.sv -----
`timescale 1ns / 1ps
// ctt_pkg: shared constants, token and error codes and result types
// for the config text tokenizer; no dependencies
package ctt_pkg;

  localparam int COUNTER_BITS = 16;

  // token kinds
  localparam logic [3:0] KIND_LBRACE    = 4'd0;
  localparam logic [3:0] KIND_RBRACE    = 4'd1;
  localparam logic [3:0] KIND_EQUALS    = 4'd2;
  localparam logic [3:0] KIND_COMMA     = 4'd3;
  localparam logic [3:0] KIND_QMARK     = 4'd4;
  localparam logic [3:0] KIND_COLON     = 4'd5;
  localparam logic [3:0] KIND_SEMICOLON = 4'd6;
  localparam logic [3:0] KIND_TEXTBYTE  = 4'd7;
  localparam logic [3:0] KIND_TEXTEND   = 4'd8;
  localparam logic [3:0] KIND_EOF       = 4'd9;
  localparam logic [3:0] KIND_ERROR     = 4'd10;

  // error codes
  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
  localparam logic [1:0] ERR_BAD_HEX    = 2'd2;
  localparam logic [1:0] ERR_END        = 2'd3;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [7:0]  content_byte;
    logic [1:0]  error_code;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_of_run;
  } result_t;

  // up to two results produced by one character
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  // clamp a position counter to the 16-bit result field
  function automatic logic [15:0] sat_count(input logic [COUNTER_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    if (w > 64'd65535) begin
      return 16'hFFFF;
    end
    return w[15:0];
  endfunction

endpackage

// ----- hdl/ctt_if.sv -----
`timescale 1ns / 1ps
// ctt_char_if / ctt_token_if: valid/ready channels for the character
// input and the token output of the tokenizer; no dependencies
interface ctt_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_end;

  modport source (output valid, output data_byte, output is_end, input ready);
  modport sink (input valid, input data_byte, input is_end, output ready);
endinterface

interface ctt_token_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [7:0]  content_byte;
  logic [1:0]  error_code;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic        last_of_run;

  modport source (output valid, output token_kind, output content_byte,
                  output error_code, output line_number, output column_number,
                  output last_of_run, input ready);
  modport sink (input valid, input token_kind, input content_byte,
                input error_code, input line_number, input column_number,
                input last_of_run, output ready);
endinterface

// ----- hdl/ctt_core.sv -----
`timescale 1ns / 1ps
// ctt_core: input register, scanner state and the per-character decision
// depends on ctt_pkg and ctt_char_if
module ctt_core (
  input  logic            clk,
  input  logic            rst,
  ctt_char_if.sink        chars,
  input  logic [1:0]      room,
  output ctt_pkg::push_t  push
);
  import ctt_pkg::*;

  typedef enum logic [2:0] {
    M_SEARCH, M_LINECMT, M_BLOCKCMT, M_QUOTED, M_HEX, M_WORD
  } mode_t;

  typedef struct packed {
    logic       emit;
    logic       fail;
    logic [3:0] kind;
    logic [7:0] content;
    mode_t      mode;
    logic [7:0] prev;
  } srch_t;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [COUNTER_BITS-1:0] COUNT_MAX = {COUNTER_BITS{1'b1}};

  function automatic logic is_space(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39) || c == 8'h2E || c == 8'h5F ||
           c == 8'h2D || c == 8'h5E;
  endfunction

  // bit 4 set means not a hex digit
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else v = 5'h10;
    return v;
  endfunction

  // bit 4 set means not punctuation
  function automatic logic [4:0] punct_kind(input logic [7:0] c);
    logic [4:0] k;
    unique case (c)
      8'h7B:   k = {1'b0, KIND_LBRACE};
      8'h7D:   k = {1'b0, KIND_RBRACE};
      8'h3D:   k = {1'b0, KIND_EQUALS};
      8'h2C:   k = {1'b0, KIND_COMMA};
      8'h3F:   k = {1'b0, KIND_QMARK};
      8'h3A:   k = {1'b0, KIND_COLON};
      8'h3B:   k = {1'b0, KIND_SEMICOLON};
      default: k = 5'h10;
    endcase
    return k;
  endfunction

  function automatic srch_t search(input logic [7:0] c, input logic [7:0] prev,
                                   input logic first_col);
    srch_t s;
    logic [4:0] pk;
    pk = punct_kind(c);
    s.emit = 1'b0;
    s.fail = 1'b0;
    s.kind = KIND_ERROR;
    s.content = c;
    s.mode = M_SEARCH;
    s.prev = c;
    if (is_space(c)) begin
      s.mode = M_SEARCH;
    end else if (first_col && (c == CH_HASH || c == CH_SEMI)) begin
      s.mode = M_LINECMT;
    end else if (prev == CH_SLASH && c == CH_SLASH) begin
      s.mode = M_LINECMT;
    end else if (prev == CH_SLASH && c == CH_STAR) begin
      s.mode = M_BLOCKCMT;
    end else if (!pk[4]) begin
      s.emit = 1'b1;
      s.kind = pk[3:0];
      s.prev = 8'h00;
    end else if (c == CH_QUOTE) begin
      s.mode = M_QUOTED;
    end else if (c == CH_LT) begin
      s.mode = M_HEX;
    end else if (is_word(c)) begin
      s.mode = M_WORD;
      s.emit = 1'b1;
      s.kind = KIND_TEXTBYTE;
    end else if (c != CH_SLASH) begin
      // unexpected character, previous char left as it was
      s.emit = 1'b1;
      s.fail = 1'b1;
      s.prev = prev;
    end
    return s;
  endfunction

  // input register
  logic       v_q;
  logic [7:0] byte_q;
  logic       end_q;

  // scanner state
  mode_t                   mode, mode_next;
  logic [7:0]              prev_char, prev_char_next;
  logic                    esc, esc_next;
  logic                    nib_valid, nib_valid_next;
  logic [3:0]              nib, nib_next;
  logic [COUNTER_BITS-1:0] line_cnt, line_cnt_next;
  logic [COUNTER_BITS-1:0] col_cnt, col_cnt_next;
  logic                    failed, failed_next;
  logic [1:0]              err_latch, err_latch_next;

  logic       fire;
  logic [1:0] cnt;
  logic [3:0] k0, k1;
  logic [7:0] b0, b1;
  logic [1:0] e0, e1;
  logic       first_col;
  logic       srch_go, srch_slot1;
  srch_t      s;
  logic [4:0] hv;

  always_comb begin
    mode_next = mode;
    prev_char_next = prev_char;
    esc_next = esc;
    nib_valid_next = nib_valid;
    nib_next = nib;
    line_cnt_next = line_cnt;
    col_cnt_next = col_cnt;
    failed_next = failed;
    err_latch_next = err_latch;
    cnt = 2'd0;
    k0 = KIND_ERROR;
    b0 = 8'h00;
    e0 = ERR_NONE;
    k1 = KIND_ERROR;
    b1 = 8'h00;
    e1 = ERR_NONE;
    first_col = 1'b0;
    srch_go = 1'b0;
    srch_slot1 = 1'b0;
    s = '0;
    hv = hex_value(byte_q);

    if (failed) begin
      cnt = 2'd1;
      k0 = KIND_ERROR;
      e0 = err_latch;
    end else if (end_q) begin
      cnt = 2'd1;
      if (mode != M_SEARCH) begin
        k0 = KIND_ERROR;
        e0 = ERR_END;
        failed_next = 1'b1;
        err_latch_next = ERR_END;
      end else begin
        k0 = KIND_EOF;
        prev_char_next = 8'h00;
      end
    end else begin
      if (byte_q == CH_NL) begin
        if (line_cnt != COUNT_MAX) line_cnt_next = line_cnt + COUNTER_BITS'(1);
        col_cnt_next = '0;
      end else if (col_cnt != COUNT_MAX) begin
        col_cnt_next = col_cnt + COUNTER_BITS'(1);
      end
      first_col = (col_cnt_next == COUNTER_BITS'(1));

      unique case (mode)
        M_SEARCH: begin
          srch_go = 1'b1;
          s = search(byte_q, prev_char, first_col);
        end
        M_LINECMT: begin
          if (byte_q == CH_NL) mode_next = M_SEARCH;
          prev_char_next = byte_q;
        end
        M_BLOCKCMT: begin
          if (byte_q == CH_SLASH && prev_char == CH_STAR) mode_next = M_SEARCH;
          prev_char_next = byte_q;
        end
        M_QUOTED: begin
          if (esc) begin
            esc_next = 1'b0;
            cnt = 2'd1;
            k0 = KIND_TEXTBYTE;
            b0 = byte_q;
            prev_char_next = byte_q;
          end else if (byte_q == CH_BSLASH) begin
            esc_next = 1'b1;
            prev_char_next = byte_q;
          end else if (byte_q == CH_QUOTE) begin
            cnt = 2'd1;
            k0 = KIND_TEXTEND;
            mode_next = M_SEARCH;
            prev_char_next = 8'h00;
          end else begin
            cnt = 2'd1;
            k0 = KIND_TEXTBYTE;
            b0 = byte_q;
            prev_char_next = byte_q;
          end
        end
        M_HEX: begin
          if (!hv[4]) begin
            if (nib_valid) begin
              cnt = 2'd1;
              k0 = KIND_TEXTBYTE;
              b0 = {nib, hv[3:0]};
              nib_valid_next = 1'b0;
            end else begin
              nib_valid_next = 1'b1;
              nib_next = hv[3:0];
            end
            prev_char_next = byte_q;
          end else if (byte_q == CH_GT) begin
            nib_valid_next = 1'b0;
            cnt = 2'd1;
            k0 = KIND_TEXTEND;
            mode_next = M_SEARCH;
            prev_char_next = 8'h00;
          end else begin
            cnt = 2'd1;
            k0 = KIND_ERROR;
            b0 = byte_q;
            e0 = ERR_BAD_HEX;
            failed_next = 1'b1;
            err_latch_next = ERR_BAD_HEX;
          end
        end
        M_WORD: begin
          if (is_word(byte_q)) begin
            cnt = 2'd1;
            k0 = KIND_TEXTBYTE;
            b0 = byte_q;
            prev_char_next = byte_q;
          end else begin
            // word ends: close it, then scan the terminator again
            cnt = 2'd1;
            k0 = KIND_TEXTEND;
            srch_go = 1'b1;
            srch_slot1 = 1'b1;
            s = search(byte_q, 8'h00, first_col);
          end
        end
        default: begin
          srch_go = 1'b1;
          s = search(byte_q, prev_char, first_col);
        end
      endcase

      if (srch_go) begin
        mode_next = s.mode;
        prev_char_next = s.prev;
        if (s.mode == M_QUOTED) esc_next = 1'b0;
        if (s.mode == M_HEX) nib_valid_next = 1'b0;
        if (s.fail) begin
          failed_next = 1'b1;
          err_latch_next = ERR_UNEXPECTED;
        end
        if (s.emit) begin
          if (srch_slot1) begin
            cnt = 2'd2;
            k1 = s.kind;
            b1 = s.content;
            e1 = s.fail ? ERR_UNEXPECTED : ERR_NONE;
          end else begin
            cnt = 2'd1;
            k0 = s.kind;
            b0 = s.content;
            e0 = s.fail ? ERR_UNEXPECTED : ERR_NONE;
          end
        end
      end
    end
  end

  assign fire = v_q && (cnt <= room);
  assign chars.ready = !v_q || fire;

  always_comb begin
    push.cnt = fire ? cnt : 2'd0;
    push.r0 = '{token_kind: k0, content_byte: b0, error_code: e0,
                line_number: sat_count(line_cnt_next),
                column_number: sat_count(col_cnt_next),
                last_of_run: (cnt == 2'd1)};
    push.r1 = '{token_kind: k1, content_byte: b1, error_code: e1,
                line_number: sat_count(line_cnt_next),
                column_number: sat_count(col_cnt_next),
                last_of_run: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
      mode <= M_SEARCH;
      prev_char <= 8'h00;
      esc <= 1'b0;
      nib_valid <= 1'b0;
      nib <= 4'h0;
      line_cnt <= '0;
      col_cnt <= '0;
      failed <= 1'b0;
      err_latch <= ERR_NONE;
    end else begin
      if (chars.valid && chars.ready) begin
        v_q <= 1'b1;
        byte_q <= chars.data_byte;
        end_q <= chars.is_end;
      end else if (fire) begin
        v_q <= 1'b0;
      end
      if (fire) begin
        mode <= mode_next;
        prev_char <= prev_char_next;
        esc <= esc_next;
        nib_valid <= nib_valid_next;
        nib <= nib_next;
        line_cnt <= line_cnt_next;
        col_cnt <= col_cnt_next;
        failed <= failed_next;
        err_latch <= err_latch_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_fail_sticky: assert property (@(posedge clk) disable iff (rst)
    failed |=> failed)
    else $error("error state left without reset");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 |-> push.r0.token_kind == KIND_TEXTEND)
    else $error("two-token beat does not start with textend");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt <= room)
    else $error("result queue overrun");
`endif

endmodule

// ----- hdl/ctt_resq.sv -----
`timescale 1ns / 1ps
// ctt_resq: two-entry result queue driving the token channel
// depends on ctt_pkg and ctt_token_if
module ctt_resq (
  input  logic            clk,
  input  logic            rst,
  input  ctt_pkg::push_t  push,
  output logic [1:0]      room,
  ctt_token_if.source     tokens
);
  import ctt_pkg::*;

  result_t    slot [2];
  result_t    slot_next [2];
  logic [1:0] occ, occ_next, base;
  logic       pop;

  assign pop = (occ != 2'd0) && tokens.ready;
  assign room = 2'd2 - occ + {1'b0, pop};
  assign base = occ - {1'b0, pop};

  always_comb begin
    slot_next[0] = slot[0];
    slot_next[1] = slot[1];
    if (pop) slot_next[0] = slot[1];
    if (push.cnt != 2'd0) begin
      if (base == 2'd0) begin
        slot_next[0] = push.r0;
        if (push.cnt == 2'd2) slot_next[1] = push.r1;
      end else begin
        slot_next[1] = push.r0;
      end
    end
    occ_next = base + push.cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 2'd0;
    end else begin
      occ <= occ_next;
    end
    slot[0] <= slot_next[0];
    slot[1] <= slot_next[1];
  end

  assign tokens.valid = (occ != 2'd0);
  assign tokens.token_kind = slot[0].token_kind;
  assign tokens.content_byte = slot[0].content_byte;
  assign tokens.error_code = slot[0].error_code;
  assign tokens.line_number = slot[0].line_number;
  assign tokens.column_number = slot[0].column_number;
  assign tokens.last_of_run = slot[0].last_of_run;

`ifndef ASSERT_OFF
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= 2'd2)
    else $error("queue occupancy out of range");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd1 |-> push.r0.last_of_run)
    else $error("single result beat not marked last");

  a_pair_last: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 |-> push.r1.last_of_run && !push.r0.last_of_run)
    else $error("result pair marked wrong");
`endif

endmodule

// ----- hdl/config_text_tokenizer_top.sv -----
`timescale 1ns / 1ps
// config_text_tokenizer_top: tokenizer top level, scanner core plus result queue
// depends on ctt_pkg, ctt_if, ctt_core and ctt_resq
//
// Takes one character (or an end mark) per beat and gives zero, one or two
// tokens for it, each tagged with line and column after that character.
// A character is accepted every cycle while the token side keeps up; its
// first token passes the input register, then the result queue. Tokens
// leave at one per cycle while the receiver is ready, through a two-entry
// queue, so throughput is set by the token count: a character that ends a
// bare word and is itself a token gives two, and it is held back unless a
// token has left the queue with none queued in its place since the last
// such character. After an error every beat gives an error token until reset.
module config_text_tokenizer_top (
  input  logic        clk,
  input  logic        rst,
  ctt_char_if.sink    chars,
  ctt_token_if.source tokens
);
  import ctt_pkg::*;

  push_t      push;
  logic [1:0] room;

  ctt_core u_core (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .room  (room),
    .push  (push)
  );

  ctt_resq u_resq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .tokens (tokens)
  );

endmodule

// ----- test/tb_config_text_tokenizer_top.sv -----
`timescale 1ns / 1ps
// tb_config_text_tokenizer_top: self-checking bench for the config text tokenizer
// depends on ctt_pkg, ctt_if and config_text_tokenizer_top; predicts every token
// in step with accepted characters and checks tokens in arrival order
module tb_config_text_tokenizer_top;
  import ctt_pkg::*;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [4:0] NO_PUNCT  = 5'h10;
  localparam logic [4:0] NO_NIBBLE = 5'h10;
  localparam int HOLD_CYCLES = 200;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_LINE_CMT, SCAN_BLOCK_CMT, SCAN_QUOTED, SCAN_HEX, SCAN_WORD
  } scan_e;

  logic clk;
  logic rst;

  ctt_char_if  chars ();
  ctt_token_if tokens ();

  config_text_tokenizer_top dut (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .tokens (tokens)
  );

  // tokenizer state mirror
  scan_e                   mode;
  logic [7:0]              prev_ch;
  logic                    esc_pending;
  logic [4:0]              high_nib;
  logic [COUNTER_BITS-1:0] line_cnt;
  logic [COUNTER_BITS-1:0] col_cnt;
  logic                    failed_st;
  logic [1:0]              err_lat;

  result_t item_toks[$];
  result_t want_q[$];

  int    mismatch_cnt = 0;
  int    sent_cnt = 0;
  int    tx_idle_pct = 0;
  int    rx_stall_pct = 0;
  event  hold_start;
  int    hold_left = 0;
  string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789._-^";
  string hex_chars = "0123456789abcdefABCDEF";

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] %s", $time, what);
    mismatch_cnt++;
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic bit is_word_ch(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "." || c == "_" || c == "-" || c == "^";
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    return NO_NIBBLE;
  endfunction

  function automatic logic [4:0] punct_code(input logic [7:0] c);
    case (c)
      CH_LBRACE: return {1'b0, KIND_LBRACE};
      CH_RBRACE: return {1'b0, KIND_RBRACE};
      CH_EQUALS: return {1'b0, KIND_EQUALS};
      CH_COMMA:  return {1'b0, KIND_COMMA};
      CH_QMARK:  return {1'b0, KIND_QMARK};
      CH_COLON:  return {1'b0, KIND_COLON};
      CH_SEMI:   return {1'b0, KIND_SEMICOLON};
      default:   return NO_PUNCT;
    endcase
  endfunction

  task automatic add_token(input logic [3:0] kind, input logic [7:0] b, input logic [1:0] code);
    result_t t;
    t = '0;
    t.token_kind   = kind;
    t.content_byte = b;
    t.error_code   = code;
    item_toks.push_back(t);
  endtask

  task automatic raise_error(input logic [1:0] code, input logic [7:0] b);
    failed_st = 1'b1;
    err_lat   = code;
    add_token(KIND_ERROR, b, code);
  endtask

  task automatic reset_model();
    mode        = SCAN_IDLE;
    prev_ch     = '0;
    esc_pending = 1'b0;
    high_nib    = '0;
    line_cnt    = '0;
    col_cnt     = '0;
    failed_st   = 1'b0;
    err_lat     = ERR_NONE;
  endtask

  task automatic scan_search(input logic [7:0] c);
    logic [4:0] pk;
    pk = punct_code(c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_NL || c == CH_FF || c == CH_VT) begin
    end else if (col_cnt == 1 && (c == CH_HASH || c == CH_SEMI)) begin
      mode = SCAN_LINE_CMT;
    end else if (prev_ch == CH_SLASH && c == CH_SLASH) begin
      mode = SCAN_LINE_CMT;
    end else if (prev_ch == CH_SLASH && c == CH_STAR) begin
      mode = SCAN_BLOCK_CMT;
    end else if (pk != NO_PUNCT) begin
      add_token(pk[3:0], c, ERR_NONE);
      prev_ch = '0;
      return;
    end else if (c == CH_DQUOTE) begin
      mode = SCAN_QUOTED;
      esc_pending = 1'b0;
    end else if (c == CH_LT) begin
      mode = SCAN_HEX;
      high_nib = '0;
    end else if (is_word_ch(c)) begin
      mode = SCAN_WORD;
      add_token(KIND_TEXTBYTE, c, ERR_NONE);
    end else if (c != CH_SLASH) begin
      raise_error(ERR_UNEXPECTED, c);
      return;
    end
    prev_ch = c;
  endtask

  task automatic predict_tokens(input logic [7:0] c, input logic e);
    logic [4:0] hv;
    item_toks.delete();
    if (failed_st) begin
      add_token(KIND_ERROR, 8'h00, err_lat);
    end else if (e) begin
      if (mode != SCAN_IDLE) begin
        raise_error(ERR_END, 8'h00);
      end else begin
        add_token(KIND_EOF, 8'h00, ERR_NONE);
        prev_ch = '0;
      end
    end else begin
      if (c == CH_NL) begin
        if (line_cnt != {COUNTER_BITS{1'b1}}) line_cnt = line_cnt + 1'b1;
        col_cnt = '0;
      end else if (col_cnt != {COUNTER_BITS{1'b1}}) begin
        col_cnt = col_cnt + 1'b1;
      end
      case (mode)
        SCAN_IDLE: scan_search(c);
        SCAN_LINE_CMT: begin
          if (c == CH_NL) mode = SCAN_IDLE;
          prev_ch = c;
        end
        SCAN_BLOCK_CMT: begin
          // the star of the opener also counts toward the close
          if (c == CH_SLASH && prev_ch == CH_STAR) mode = SCAN_IDLE;
          prev_ch = c;
        end
        SCAN_QUOTED: begin
          if (esc_pending) begin
            esc_pending = 1'b0;
            add_token(KIND_TEXTBYTE, c, ERR_NONE);
            prev_ch = c;
          end else if (c == CH_BSLASH) begin
            esc_pending = 1'b1;
            prev_ch = c;
          end else if (c == CH_DQUOTE) begin
            add_token(KIND_TEXTEND, 8'h00, ERR_NONE);
            mode = SCAN_IDLE;
            prev_ch = '0;
          end else begin
            add_token(KIND_TEXTBYTE, c, ERR_NONE);
            prev_ch = c;
          end
        end
        SCAN_HEX: begin
          hv = hex_nibble(c);
          if (hv != NO_NIBBLE) begin
            if (high_nib[4]) begin
              add_token(KIND_TEXTBYTE, {high_nib[3:0], hv[3:0]}, ERR_NONE);
              high_nib = '0;
            end else begin
              high_nib = {1'b1, hv[3:0]};
            end
            prev_ch = c;
          end else if (c == CH_GT) begin
            // odd digit count: the leftover high nibble is dropped
            high_nib = '0;
            add_token(KIND_TEXTEND, 8'h00, ERR_NONE);
            mode = SCAN_IDLE;
            prev_ch = '0;
          end else begin
            raise_error(ERR_BAD_HEX, c);
          end
        end
        SCAN_WORD: begin
          if (is_word_ch(c)) begin
            add_token(KIND_TEXTBYTE, c, ERR_NONE);
            prev_ch = c;
          end else begin
            // word terminator is scanned again without recounting
            add_token(KIND_TEXTEND, 8'h00, ERR_NONE);
            mode = SCAN_IDLE;
            prev_ch = '0;
            scan_search(c);
          end
        end
      endcase
    end
    foreach (item_toks[i]) begin
      item_toks[i].line_number   = (64'(line_cnt) > 64'd65535) ? 16'hFFFF : line_cnt[15:0];
      item_toks[i].column_number = (64'(col_cnt) > 64'd65535) ? 16'hFFFF : col_cnt[15:0];
      item_toks[i].last_of_run   = (i == item_toks.size() - 1);
      want_q.push_back(item_toks[i]);
    end
  endtask

  // ---------------------------------------------------------------- token side

  // long receiver hold, counted here in cycles
  always begin : rx_hold
    @(hold_start);
    hold_left = HOLD_CYCLES;
    while (hold_left > 0) begin
      @(negedge clk);
      hold_left--;
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      tokens.ready <= 1'b0;
    end else begin
      tokens.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : token_check
    result_t got;
    result_t want;
    if (!rst && tokens.valid && tokens.ready) begin
      got.token_kind    = tokens.token_kind;
      got.content_byte  = tokens.content_byte;
      got.error_code    = tokens.error_code;
      got.line_number   = tokens.line_number;
      got.column_number = tokens.column_number;
      got.last_of_run   = tokens.last_of_run;
      if (want_q.size() == 0) begin
        report_mismatch($sformatf("unexpected token: kind %0d byte %02h",
                                  got.token_kind, got.content_byte));
      end else begin
        want = want_q.pop_front();
        if (got.token_kind !== want.token_kind || got.content_byte !== want.content_byte ||
            got.error_code !== want.error_code || got.line_number !== want.line_number ||
            got.column_number !== want.column_number ||
            got.last_of_run !== want.last_of_run) begin
          report_mismatch($sformatf(
            "token got k%0d b%02h e%0d l%0d c%0d z%0b, want k%0d b%02h e%0d l%0d c%0d z%0b",
            got.token_kind, got.content_byte, got.error_code, got.line_number,
            got.column_number, got.last_of_run, want.token_kind, want.content_byte,
            want.error_code, want.line_number, want.column_number, want.last_of_run));
        end
      end
    end
  end

  // ---------------------------------------------------------------- character side

  task automatic send_char(input logic [7:0] b, input logic e);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      chars.valid <= 1'b0;
      @(negedge clk);
    end
    chars.valid     <= 1'b1;
    chars.data_byte <= b;
    chars.is_end    <= e;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    predict_tokens(b, e);
    sent_cnt++;
  endtask

  task automatic send_str(input string s);
    foreach (s[i]) send_char(s[i], 1'b0);
  endtask

  task automatic close_comment();
    if (mode == SCAN_LINE_CMT) send_char(CH_NL, 1'b0);
    else if (mode == SCAN_BLOCK_CMT) send_str("*/");
  endtask

  task automatic settle_idle();
    close_comment();
    if (mode == SCAN_WORD) send_char(CH_SPACE, 1'b0);
  endtask

  function automatic logic [7:0] rand_word_ch();
    return word_chars[$urandom_range(0, word_chars.len() - 1)];
  endfunction

  task automatic send_word(input int len);
    repeat (len) send_char(rand_word_ch(), 1'b0);
  endtask

  task automatic send_punct();
    case ($urandom_range(0, 6))
      0: send_char(CH_LBRACE, 1'b0);
      1: send_char(CH_RBRACE, 1'b0);
      2: send_char(CH_EQUALS, 1'b0);
      3: send_char(CH_COMMA, 1'b0);
      4: send_char(CH_QMARK, 1'b0);
      5: send_char(CH_COLON, 1'b0);
      default: send_char(CH_SEMI, 1'b0);
    endcase
  endtask

  // one well-formed piece of text with random content; never drives an error
  task automatic random_fragment();
    logic [7:0] b;
    int         len;
    len = $urandom_range(0, 10);
    case ($urandom_range(0, 13))
      0: begin
        case ($urandom_range(0, 4))
          0: send_char(CH_TAB, 1'b0);
          1: send_char(CH_VT, 1'b0);
          2: send_char(CH_FF, 1'b0);
          3: send_char(CH_CR, 1'b0);
          default: send_char(CH_SPACE, 1'b0);
        endcase
      end
      1: send_char(CH_NL, 1'b0);
      2: send_punct();
      3, 4: send_word($urandom_range(1, 8));
      5, 6: begin
        close_comment();
        send_char(CH_DQUOTE, 1'b0);
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          if (b == CH_DQUOTE || b == CH_BSLASH || $urandom_range(0, 7) == 0)
            send_char(CH_BSLASH, 1'b0);
          send_char(b, 1'b0);
        end
        send_char(CH_DQUOTE, 1'b0);
      end
      7: begin
        close_comment();
        send_char(CH_LT, 1'b0);
        repeat (len) send_char(hex_chars[$urandom_range(0, hex_chars.len() - 1)], 1'b0);
        send_char(CH_GT, 1'b0);
      end
      8: begin
        close_comment();
        if (mode == SCAN_IDLE && col_cnt == 0)
          send_char($urandom_range(0, 1) ? CH_HASH : CH_SEMI, 1'b0);
        else
          send_str("//");
        repeat (len) begin
          b = 8'($urandom_range(0, 255));
          send_char((b == CH_NL) ? CH_SPACE : b, 1'b0);
        end
        send_char(CH_NL, 1'b0);
      end
      9: begin
        close_comment();
        // a slash left pending would turn the opener into a line comment
        if (mode == SCAN_IDLE && prev_ch == CH_SLASH) send_char(CH_SPACE, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
          send_str("/*/");
        end else begin
          send_str("/*");
          repeat (len) begin
            b = 8'($urandom_range(0, 255));
            send_char((b == CH_SLASH) ? CH_STAR : b, 1'b0);
          end
          send_str("*/");
        end
      end
      10: send_str("/ ");
      11: begin
        settle_idle();
        send_char(8'($urandom_range(0, 255)), 1'b1);
      end
      12: begin
        send_word($urandom_range(1, 4));
        send_punct();
      end
      default: begin
        send_word($urandom_range(1, 6));
        send_char(CH_NL, 1'b0);
      end
    endcase
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_comments();
    send_str("#\n;\n/\t//\n/*/");
  endtask

  task automatic test_punctuation();
    // the brace also closes the word, so it gives two tokens
    send_str("w{}=,?:;");
  endtask

  task automatic test_strings();
    send_char(CH_DQUOTE, 1'b0);
    send_char(CH_BSLASH, 1'b0);
    send_char(CH_DQUOTE, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(CH_DQUOTE, 1'b0);
    send_str("<aF3>");
  endtask

  task automatic test_end_mark();
    send_char(8'hA5, 1'b1);
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    -> hold_start;
    repeat (40) send_str("k,");
  endtask

  task automatic run_random_phase(input int tx_pct, input int rx_pct, input int n_items);
    int target;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    target = sent_cnt + n_items;
    while (sent_cnt < target) random_fragment();
  endtask

  task automatic test_random_streams();
    run_random_phase(0, 0, 95);
    run_random_phase(63, 0, 95);
    run_random_phase(0, 63, 95);
    run_random_phase(22, 22, 95);
    settle_idle();
  endtask

  // only one error per run, since nothing but reset clears it
  task automatic test_sticky_error();
    tx_idle_pct = 22;
    rx_stall_pct = 22;
    settle_idle();
    case ($urandom_range(1, 3))
      1: send_char(8'($urandom_range(128, 255)), 1'b0);
      2: begin
        send_char(CH_LT, 1'b0);
        if ($urandom_range(0, 1)) send_char("7", 1'b0);
        send_char(8'($urandom_range(8'h67, 8'h7A)), 1'b0);
      end
      default: begin
        case ($urandom_range(0, 4))
          0: send_char("w", 1'b0);
          1: send_char(CH_DQUOTE, 1'b0);
          2: send_char(CH_LT, 1'b0);
          3: send_str("//");
          default: send_str("/*");
        endcase
        send_char(8'h00, 1'b1);
      end
    endcase
    repeat (3) send_char(8'($urandom_range(0, 255)), 1'b0);
    send_char(8'h00, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    chars.valid = 1'b0;
    chars.data_byte = 8'h00;
    chars.is_end = 1'b0;
    reset_model();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_comments();
    test_punctuation();
    test_strings();
    test_end_mark();
    test_backpressure();
    test_random_streams();
    test_sticky_error();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    @(negedge clk);
    chars.valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
